// ===== sv/kmts_pkg.sv =====
`timescale 1ns / 1ps

package kmts_pkg;

    localparam int unsigned KEY_W  = 16;
    localparam int unsigned DATA_W = 16;
    localparam int unsigned OUT_W  = 8;

    // key positions in a scan word
    localparam int unsigned KEY_ESC = 1;
    localparam int unsigned KEY_ENT = 3;
    localparam int unsigned KEY_B1  = 5;
    localparam int unsigned KEY_B2  = 6;
    localparam int unsigned KEY_B3  = 7;
    localparam int unsigned KEY_B4  = 9;
    localparam int unsigned KEY_B5  = 10;

    // output level positions
    localparam int unsigned OB_SDOWN = 0;
    localparam int unsigned OB_SUP   = 1;
    localparam int unsigned OB_END   = 2;
    localparam int unsigned OB_CNT   = 3;
    localparam int unsigned OB_START = 4;
    localparam int unsigned OB_RED   = 5;
    localparam int unsigned OB_GREEN = 6;
    localparam int unsigned OB_YEL   = 7;

    // lamp patterns with the five outputs cleared
    localparam logic [OUT_W-1:0] LAMPS_RUN = 8'hC0;
    localparam logic [OUT_W-1:0] LAMPS_IO  = 8'hA0;
    localparam logic [OUT_W-1:0] LAMPS_OPT = 8'h60;
    localparam logic [OUT_W-1:0] FIVE_MASK = 8'h1F;

    localparam logic [DATA_W-1:0] SLACK_ON_RESET = 16'd20;
    localparam logic [DATA_W-1:0] START_ON_RESET = 16'd40;
    localparam logic [DATA_W-1:0] HOLD_RESET     = 16'd80;
    localparam logic [DATA_W-1:0] END_STOP_RESET = 16'd120;

    typedef enum logic [1:0] {
        MENU_NONE = 2'd0,
        MENU_RUN  = 2'd1,
        MENU_IO   = 2'd2,
        MENU_OPT  = 2'd3
    } menu_t;

    typedef enum logic [1:0] {
        CFG_SLACK_ON = 2'd0,
        CFG_START_ON = 2'd1,
        CFG_HOLD     = 2'd2,
        CFG_END_STOP = 2'd3
    } cfg_index_t;

    localparam logic ITEM_SCAN = 1'b0;
    localparam logic ITEM_TICK = 1'b1;

endpackage

// ===== sv/kmts_item_if.sv =====
`timescale 1ns / 1ps

interface kmts_item_if;
    logic                        valid;
    logic                        ready;
    logic                        mode;
    logic [kmts_pkg::KEY_W-1:0]  keys;

    modport source (output valid, output mode, output keys, input ready);
    modport sink   (input valid, input mode, input keys, output ready);
endinterface

// ===== sv/kmts_result_if.sv =====
`timescale 1ns / 1ps

interface kmts_result_if;
    logic                        valid;
    logic                        ready;
    logic                        slack_down;
    logic                        slack_up;
    logic                        end_stop;
    logic                        count_pulse;
    logic                        start_out;
    logic                        red_led;
    logic                        green_led;
    logic                        yellow_led;
    logic [1:0]                  menu_mode;
    logic                        running;
    logic [kmts_pkg::DATA_W-1:0] pulses_done;
    logic [kmts_pkg::KEY_W-1:0]  released_keys;

    modport source (
        output valid, output slack_down, output slack_up, output end_stop,
        output count_pulse, output start_out, output red_led, output green_led,
        output yellow_led, output menu_mode, output running, output pulses_done,
        output released_keys, input ready
    );
    modport sink (
        input valid, input slack_down, input slack_up, input end_stop,
        input count_pulse, input start_out, input red_led, input green_led,
        input yellow_led, input menu_mode, input running, input pulses_done,
        input released_keys, output ready
    );
endinterface

// ===== sv/kmts_cfg_if.sv =====
`timescale 1ns / 1ps

interface kmts_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  index;
    logic [kmts_pkg::DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/keypad_menu_test_sequencer.sv =====
`timescale 1ns / 1ps
// a word is registered on entry and its result is registered in the result register,
// which takes it only when the result register is empty or its result is being taken
// throughput: one word per cycle while the result side keeps taking results; the menu and tick
// update is one pass of logic between the entry register and the result register
// reset: asynchronous active low; run mode, test stopped, counters zero, green and
// yellow lamps on, configuration back to 20/40/80/120
module keypad_menu_test_sequencer (
    input  logic            clk,
    input  logic            rst_n,
    kmts_item_if.sink       item,
    kmts_result_if.source   result,
    kmts_cfg_if.sink        cfg
);

    // configuration
    logic [kmts_pkg::DATA_W-1:0] slack_on_reg;
    logic [kmts_pkg::DATA_W-1:0] start_on_reg;
    logic [kmts_pkg::DATA_W-1:0] hold_reg;
    logic [kmts_pkg::DATA_W-1:0] end_stop_reg;

    // entry stage
    logic                        s1_valid_reg;
    logic                        s1_mode_reg;
    logic [kmts_pkg::KEY_W-1:0]  s1_keys_reg;

    // sequencer state
    logic [kmts_pkg::KEY_W-1:0]  prev_keys_reg;
    kmts_pkg::menu_t             menu_reg, menu_next;
    logic                        run_reg, run_next;
    logic                        counting_reg, counting_next;
    logic [kmts_pkg::DATA_W-1:0] tick_reg, tick_next;
    logic [kmts_pkg::DATA_W-1:0] tally_reg, tally_next;
    logic [kmts_pkg::OUT_W-1:0]  obits_reg, obits_next;
    logic [kmts_pkg::KEY_W-1:0]  released;

    // result stage
    logic                        res_valid_reg;
    logic [kmts_pkg::OUT_W-1:0]  res_obits_reg;
    kmts_pkg::menu_t             res_menu_reg;
    logic                        res_run_reg;
    logic [kmts_pkg::DATA_W-1:0] res_tally_reg;
    logic [kmts_pkg::KEY_W-1:0]  res_released_reg;

    logic                        fire;

    assign fire       = s1_valid_reg && (!res_valid_reg || result.ready);
    assign item.ready = !s1_valid_reg || fire;
    assign cfg.ready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slack_on_reg <= kmts_pkg::SLACK_ON_RESET;
            start_on_reg <= kmts_pkg::START_ON_RESET;
            hold_reg     <= kmts_pkg::HOLD_RESET;
            end_stop_reg <= kmts_pkg::END_STOP_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (kmts_pkg::cfg_index_t'(cfg.index))
                kmts_pkg::CFG_SLACK_ON: slack_on_reg <= cfg.data;
                kmts_pkg::CFG_START_ON: start_on_reg <= cfg.data;
                kmts_pkg::CFG_HOLD:     hold_reg     <= cfg.data;
                kmts_pkg::CFG_END_STOP: end_stop_reg <= cfg.data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            s1_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.ready && item.valid)
        begin
            s1_mode_reg <= item.mode;
            s1_keys_reg <= item.keys;
        end
    end

    always_comb
    begin
        logic [kmts_pkg::KEY_W-1:0] ev;
        ev            = '0;
        released      = '0;
        menu_next     = menu_reg;
        run_next      = run_reg;
        counting_next = counting_reg;
        tick_next     = tick_reg;
        tally_next    = tally_reg;
        obits_next    = obits_reg;

        if (s1_mode_reg == kmts_pkg::ITEM_SCAN)
        begin
            released = prev_keys_reg & ~s1_keys_reg;
            ev       = released;
            unique case (menu_reg)
                kmts_pkg::MENU_RUN:
                begin
                    if (ev[kmts_pkg::KEY_B1])
                    begin
                        if (!run_reg)
                        begin
                            obits_next = obits_reg & ~kmts_pkg::FIVE_MASK;
                            tick_next  = '0;
                            tally_next = '0;
                            run_next   = 1'b1;
                        end
                        else
                        begin
                            obits_next = kmts_pkg::LAMPS_RUN;
                            run_next   = 1'b0;
                        end
                    end
                    // esc swallows the rest of this scan, so ent is ignored
                    if (!ev[kmts_pkg::KEY_ESC] && ev[kmts_pkg::KEY_ENT])
                    begin
                        run_next   = 1'b0;
                        obits_next = kmts_pkg::LAMPS_IO;
                        menu_next  = kmts_pkg::MENU_IO;
                    end
                end
                kmts_pkg::MENU_IO:
                begin
                    obits_next[kmts_pkg::OB_SDOWN] =
                        obits_reg[kmts_pkg::OB_SDOWN] ^ ev[kmts_pkg::KEY_B1];
                    obits_next[kmts_pkg::OB_SUP] =
                        obits_reg[kmts_pkg::OB_SUP] ^ ev[kmts_pkg::KEY_B2];
                    obits_next[kmts_pkg::OB_START] =
                        obits_reg[kmts_pkg::OB_START] ^ ev[kmts_pkg::KEY_B3];
                    obits_next[kmts_pkg::OB_CNT] =
                        obits_reg[kmts_pkg::OB_CNT] ^ ev[kmts_pkg::KEY_B4];
                    obits_next[kmts_pkg::OB_END] =
                        obits_reg[kmts_pkg::OB_END] ^ ev[kmts_pkg::KEY_B5];
                    priority if (ev[kmts_pkg::KEY_ESC])
                    begin
                        obits_next = kmts_pkg::LAMPS_RUN;
                        menu_next  = kmts_pkg::MENU_RUN;
                    end
                    else if (ev[kmts_pkg::KEY_ENT])
                    begin
                        obits_next = kmts_pkg::LAMPS_OPT;
                        menu_next  = kmts_pkg::MENU_OPT;
                    end
                end
                kmts_pkg::MENU_OPT:
                begin
                    if (ev[kmts_pkg::KEY_ESC])
                    begin
                        obits_next = kmts_pkg::LAMPS_IO;
                        menu_next  = kmts_pkg::MENU_IO;
                    end
                end
                kmts_pkg::MENU_NONE:
                begin
                    // unreachable menu code, scan only updates the previous keys
                end
            endcase
        end
        else if (run_reg)
        begin
            obits_next[kmts_pkg::OB_RED] = ~obits_reg[kmts_pkg::OB_RED];
            tick_next = tick_reg + 1'b1;
            if (tick_next == slack_on_reg)
            begin
                obits_next[kmts_pkg::OB_SDOWN] = 1'b1;
            end
            if (tick_next == start_on_reg)
            begin
                obits_next[kmts_pkg::OB_START] = 1'b1;
            end
            if (tick_next == end_stop_reg)
            begin
                obits_next[kmts_pkg::OB_END] = 1'b1;
                counting_next = 1'b1;
            end
            if (tick_next > hold_reg && counting_next)
            begin
                if (tick_next[1])
                begin
                    obits_next[kmts_pkg::OB_CNT] = 1'b1;
                end
                else
                begin
                    tally_next = tally_reg + 1'b1;
                    obits_next[kmts_pkg::OB_CNT] = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_keys_reg <= '0;
            menu_reg      <= kmts_pkg::MENU_RUN;
            run_reg       <= 1'b0;
            counting_reg  <= 1'b0;
            tick_reg      <= '0;
            tally_reg     <= '0;
            obits_reg     <= kmts_pkg::LAMPS_RUN;
        end
        else if (fire)
        begin
            if (s1_mode_reg == kmts_pkg::ITEM_SCAN)
            begin
                prev_keys_reg <= s1_keys_reg;
            end
            menu_reg     <= menu_next;
            run_reg      <= run_next;
            counting_reg <= counting_next;
            tick_reg     <= tick_next;
            tally_reg    <= tally_next;
            obits_reg    <= obits_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_obits_reg    <= obits_next;
            res_menu_reg     <= menu_next;
            res_run_reg      <= run_next;
            res_tally_reg    <= tally_next;
            res_released_reg <= released;
        end
    end

    assign result.valid         = res_valid_reg;
    assign result.slack_down    = res_obits_reg[kmts_pkg::OB_SDOWN];
    assign result.slack_up      = res_obits_reg[kmts_pkg::OB_SUP];
    assign result.end_stop      = res_obits_reg[kmts_pkg::OB_END];
    assign result.count_pulse   = res_obits_reg[kmts_pkg::OB_CNT];
    assign result.start_out     = res_obits_reg[kmts_pkg::OB_START];
    assign result.red_led       = res_obits_reg[kmts_pkg::OB_RED];
    assign result.green_led     = res_obits_reg[kmts_pkg::OB_GREEN];
    assign result.yellow_led    = res_obits_reg[kmts_pkg::OB_YEL];
    assign result.menu_mode     = res_menu_reg;
    assign result.running       = res_run_reg;
    assign result.pulses_done   = res_tally_reg;
    assign result.released_keys = res_released_reg;

    // a test only runs in run mode
    a_run_in_run_mode: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg |-> (menu_reg == kmts_pkg::MENU_RUN))
        else $error("test running outside run mode");

    // the unused menu code is never entered
    a_menu_code: assert property (@(posedge clk) disable iff (!rst_n)
        menu_reg != kmts_pkg::MENU_NONE)
        else $error("menu left the defined modes");

    // a stopped tick leaves the counters alone
    a_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && s1_mode_reg == kmts_pkg::ITEM_TICK && !run_reg)
            |=> ($stable(tick_reg) && $stable(tally_reg) && $stable(obits_reg)))
        else $error("stopped tick changed state");

    // a tick reports no release edges
    a_tick_no_release: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && s1_mode_reg == kmts_pkg::ITEM_TICK) |=> (res_released_reg == '0))
        else $error("tick reported released keys");

    // every processed word lands in the result register
    a_fire_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> res_valid_reg)
        else $error("processed word produced no result");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import kmts_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int LONG_HOLD   = 300;
    localparam int PHASE_WORDS = 120;
    localparam int MAX_REPORTS = 10;

    localparam logic [KEY_W-1:0] K_ESC = 16'd1 << KEY_ESC;
    localparam logic [KEY_W-1:0] K_ENT = 16'd1 << KEY_ENT;
    localparam logic [KEY_W-1:0] K_B1  = 16'd1 << KEY_B1;
    localparam logic [KEY_W-1:0] K_B2  = 16'd1 << KEY_B2;
    localparam logic [KEY_W-1:0] K_B3  = 16'd1 << KEY_B3;
    localparam logic [KEY_W-1:0] K_B4  = 16'd1 << KEY_B4;
    localparam logic [KEY_W-1:0] K_B5  = 16'd1 << KEY_B5;
    localparam logic [KEY_W-1:0] MENU_KEYS = K_ESC | K_ENT | K_B1 | K_B2 | K_B3 | K_B4 | K_B5;

    typedef struct packed {
        logic             mode;
        logic [KEY_W-1:0] keys;
    } scan_word_t;

    typedef struct packed {
        logic              slack_down;
        logic              slack_up;
        logic              end_stop;
        logic              count_pulse;
        logic              start_out;
        logic              red_led;
        logic              green_led;
        logic              yellow_led;
        menu_t             menu_mode;
        logic              running;
        logic [DATA_W-1:0] pulses_done;
        logic [KEY_W-1:0]  released_keys;
    } seq_result_t;

    logic clk;
    logic rst_n;

    kmts_item_if   item_ch ();
    kmts_result_if result_ch ();
    kmts_cfg_if    cfg_ch ();

    keypad_menu_test_sequencer u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    scan_word_t  pending_words[$];
    seq_result_t expected_results[$];
    int          mismatches  = 0;
    bit          sender_hold = 1'b0;
    bit          rx_hold_req = 1'b0;

    // sequencer state as seen by the testbench
    logic [DATA_W-1:0] cfg_slack_on  = SLACK_ON_RESET;
    logic [DATA_W-1:0] cfg_start_on  = START_ON_RESET;
    logic [DATA_W-1:0] cfg_hold      = HOLD_RESET;
    logic [DATA_W-1:0] cfg_end_stop  = END_STOP_RESET;
    logic [KEY_W-1:0]  last_scan     = '0;
    menu_t             menu_q        = MENU_RUN;
    logic              test_running  = 1'b0;
    logic              count_enabled = 1'b0;
    logic [DATA_W-1:0] ticks         = '0;
    logic [DATA_W-1:0] pulse_count   = '0;
    logic [OUT_W-1:0]  levels        = LAMPS_RUN;

    function automatic void enter_menu(menu_t m);
        case (m)
            MENU_RUN: levels = LAMPS_RUN;
            MENU_IO:  levels = LAMPS_IO;
            default:  levels = LAMPS_OPT;
        endcase
        menu_q = m;
    endfunction

    function automatic seq_result_t step_sequencer(scan_word_t w);
        logic [KEY_W-1:0] rel;
        logic [KEY_W-1:0] ev;
        seq_result_t      r;
        rel = '0;
        if (w.mode == ITEM_SCAN)
        begin
            rel = last_scan & ~w.keys;
            last_scan = w.keys;
            ev = rel;
            case (menu_q)
                MENU_RUN:
                begin
                    if (ev[KEY_B1])
                    begin
                        if (!test_running)
                        begin
                            levels = levels & ~FIVE_MASK;
                            ticks = '0;
                            pulse_count = '0;
                            test_running = 1'b1;
                        end
                        else
                        begin
                            enter_menu(MENU_RUN);
                            test_running = 1'b0;
                        end
                    end
                    // esc swallows whatever else was released in this scan
                    if (ev[KEY_ESC])
                        ev = '0;
                    if (ev[KEY_ENT])
                    begin
                        test_running = 1'b0;
                        enter_menu(MENU_IO);
                    end
                end
                MENU_IO:
                begin
                    if (ev[KEY_B1]) levels[OB_SDOWN] = ~levels[OB_SDOWN];
                    if (ev[KEY_B2]) levels[OB_SUP]   = ~levels[OB_SUP];
                    if (ev[KEY_B3]) levels[OB_START] = ~levels[OB_START];
                    if (ev[KEY_B4]) levels[OB_CNT]   = ~levels[OB_CNT];
                    if (ev[KEY_B5]) levels[OB_END]   = ~levels[OB_END];
                    if (ev[KEY_ESC])
                        enter_menu(MENU_RUN);
                    else if (ev[KEY_ENT])
                        enter_menu(MENU_OPT);
                end
                MENU_OPT:
                begin
                    if (ev[KEY_ESC])
                        enter_menu(MENU_IO);
                end
                default: ;
            endcase
        end
        else if (test_running)
        begin
            levels[OB_RED] = ~levels[OB_RED];
            ticks = ticks + 1'b1;
            if (ticks == cfg_slack_on) levels[OB_SDOWN] = 1'b1;
            if (ticks == cfg_start_on) levels[OB_START] = 1'b1;
            if (ticks == cfg_end_stop)
            begin
                levels[OB_END] = 1'b1;
                count_enabled = 1'b1;
            end
            if (ticks > cfg_hold && count_enabled)
            begin
                if (ticks[1])
                    levels[OB_CNT] = 1'b1;
                else
                begin
                    pulse_count = pulse_count + 1'b1;
                    levels[OB_CNT] = 1'b0;
                end
            end
        end
        r.slack_down    = levels[OB_SDOWN];
        r.slack_up      = levels[OB_SUP];
        r.end_stop      = levels[OB_END];
        r.count_pulse   = levels[OB_CNT];
        r.start_out     = levels[OB_START];
        r.red_led       = levels[OB_RED];
        r.green_led     = levels[OB_GREEN];
        r.yellow_led    = levels[OB_YEL];
        r.menu_mode     = menu_q;
        r.running       = test_running;
        r.pulses_done   = pulse_count;
        r.released_keys = rel;
        return r;
    endfunction

    function automatic string show_result(seq_result_t r);
        return $sformatf("sd=%b su=%b es=%b cp=%b st=%b r=%b g=%b y=%b menu=%0d run=%b pulses=%0d rel=%h",
                         r.slack_down, r.slack_up, r.end_stop, r.count_pulse, r.start_out,
                         r.red_led, r.green_led, r.yellow_led, r.menu_mode, r.running,
                         r.pulses_done, r.released_keys);
    endfunction

    initial
    begin : clock_gen
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin : reset_gen
        rst_n = 1'b0;
        item_ch.valid   = 1'b0;
        item_ch.mode    = ITEM_SCAN;
        item_ch.keys    = '0;
        result_ch.ready = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = CFG_SLACK_ON;
        cfg_ch.data     = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    // sender: bursts of words with random gaps
    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge clk or negedge rst_n)
    begin : word_driver
        scan_word_t w;
        if (!rst_n)
        begin
            item_ch.valid <= 1'b0;
            item_ch.mode  <= ITEM_SCAN;
            item_ch.keys  <= '0;
        end
        else
        begin
            if (item_ch.valid && item_ch.ready)
                expected_results.push_back(step_sequencer({item_ch.mode, item_ch.keys}));
            // a word still waiting for ready stays on the bus untouched
            if (!(item_ch.valid && !item_ch.ready))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    item_ch.valid <= 1'b0;
                end
                else if (!sender_hold && pending_words.size() > 0)
                begin
                    w = pending_words.pop_front();
                    item_ch.valid <= 1'b1;
                    item_ch.mode  <= w.mode;
                    item_ch.keys  <= w.keys;
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                    end
                end
                else
                    item_ch.valid <= 1'b0;
            end
        end
    end

    // receiver: checks results and stalls on its own pattern
    int       hold_left  = 0;
    int       style      = 0;
    int       style_left = 0;
    bit [7:0] rx_phase   = '0;

    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        seq_result_t got;
        seq_result_t want;
        logic        rdy;
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                got.slack_down    = result_ch.slack_down;
                got.slack_up      = result_ch.slack_up;
                got.end_stop      = result_ch.end_stop;
                got.count_pulse   = result_ch.count_pulse;
                got.start_out     = result_ch.start_out;
                got.red_led       = result_ch.red_led;
                got.green_led     = result_ch.green_led;
                got.yellow_led    = result_ch.yellow_led;
                got.menu_mode     = menu_t'(result_ch.menu_mode);
                got.running       = result_ch.running;
                got.pulses_done   = result_ch.pulses_done;
                got.released_keys = result_ch.released_keys;
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected result word: %s", show_result(got));
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("mismatch at %0t\n  expected %s\n  actual   %s",
                                     $realtime, show_result(want), show_result(got));
                    end
                end
            end

            rx_phase = rx_phase + 1'b1;
            if (rx_hold_req)
            begin
                hold_left   = LONG_HOLD;
                rx_hold_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rdy = 1'b0;
            end
            else
            begin
                if (style_left == 0)
                begin
                    style      = $urandom_range(0, 3);
                    style_left = $urandom_range(20, 120);
                end
                style_left--;
                case (style)
                    0:       rdy = 1'b1;
                    1:       rdy = 1'($urandom_range(0, 1));
                    2:       rdy = (rx_phase[2:0] != 3'd0) && (rx_phase[4:3] != 2'd3);
                    default: rdy = ($urandom_range(0, 7) != 0);
                endcase
            end
            result_ch.ready <= rdy;
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Some tests failed");
        $finish;
    end

    task automatic push_word(input logic mode, input logic [KEY_W-1:0] keys);
        scan_word_t w;
        w.mode = mode;
        w.keys = keys;
        pending_words.push_back(w);
    endtask

    // press, then release everything
    task automatic queue_press(input logic [KEY_W-1:0] keys);
        push_word(ITEM_SCAN, keys);
        push_word(ITEM_SCAN, '0);
    endtask

    task automatic queue_ticks(input int n);
        repeat (n) push_word(ITEM_TICK, KEY_W'($urandom));
    endtask

    task automatic wait_idle();
        while (pending_words.size() != 0 || item_ch.valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(input cfg_index_t idx, input logic [DATA_W-1:0] value);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        cfg_ch.valid <= 1'b0;
        case (idx)
            CFG_SLACK_ON: cfg_slack_on = value;
            CFG_START_ON: cfg_start_on = value;
            CFG_HOLD:     cfg_hold     = value;
            default:      cfg_end_stop = value;
        endcase
    endtask

    task automatic apply_setting(input logic [DATA_W-1:0] slack_on,
                                 input logic [DATA_W-1:0] start_on,
                                 input logic [DATA_W-1:0] hold,
                                 input logic [DATA_W-1:0] end_stop);
        write_register(CFG_SLACK_ON, slack_on);
        write_register(CFG_START_ON, start_on);
        write_register(CFG_HOLD, hold);
        write_register(CFG_END_STOP, end_stop);
    endtask

    task automatic queue_random_words(input int target);
        int               added;
        int               pick;
        int               n;
        logic [KEY_W-1:0] k;
        added = 0;
        while (added < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 25)
            begin
                // back to run mode, start or stop, then a run of ticks
                queue_press(K_ESC);
                queue_press(K_ESC);
                queue_press(K_B1);
                n = $urandom_range(4, 30);
                queue_ticks(n);
                added += 6 + n;
            end
            else if (pick < 50)
            begin
                n = $urandom_range(1, 6);
                queue_ticks(n);
                added += n;
            end
            else if (pick < 85)
            begin
                if ($urandom_range(0, 3) == 0)
                    k = KEY_W'($urandom) & MENU_KEYS;
                else
                    case ($urandom_range(0, 6))
                        0:       k = K_ESC;
                        1:       k = K_ENT;
                        2:       k = K_B1;
                        3:       k = K_B2;
                        4:       k = K_B3;
                        5:       k = K_B4;
                        default: k = K_B5;
                    endcase
                push_word(ITEM_SCAN, k);
                // sometimes only part of the keys come up
                push_word(ITEM_SCAN, ($urandom_range(0, 3) == 0) ? (k & KEY_W'($urandom)) : '0);
                added += 2;
            end
            else
            begin
                push_word(ITEM_SCAN, KEY_W'($urandom));
                added += 1;
            end
        end
    endtask

    initial
    begin : stimulus
        while (rst_n !== 1'b1) @(posedge clk);
        repeat (2) @(posedge clk);

        // directed words with the reset configuration
        push_word(ITEM_TICK, '0);
        push_word(ITEM_SCAN, '1);
        push_word(ITEM_SCAN, '0);
        push_word(ITEM_TICK, '1);
        push_word(ITEM_TICK, '0);
        queue_press(K_B1);
        queue_press(K_ENT);
        queue_press(K_B1 | K_B2 | K_B3 | K_B4 | K_B5);
        queue_press(K_B2 | K_B4);
        queue_press(K_ENT);
        queue_press(K_B1);
        queue_press(K_ESC | K_ENT);
        queue_press(K_ESC | K_ENT);
        queue_press(K_B1);
        push_word(ITEM_TICK, '0);
        queue_press(K_ENT);
        wait_idle();

        // short times so runs get into counting; receiver holds off while the sender keeps on
        apply_setting(16'd2, 16'd3, 16'd5, 16'd6);
        queue_random_words(PHASE_WORDS);
        rx_hold_req = 1'b1;
        while (rx_hold_req) @(posedge clk);
        wait_idle();

        // sender pauses mid-phase until the block has drained
        apply_setting(16'd0, 16'hFFFF, 16'd0, 16'd1);
        queue_random_words(PHASE_WORDS / 2);
        while (pending_words.size() > 10) @(posedge clk);
        sender_hold = 1'b1;
        while (item_ch.valid || expected_results.size() != 0) @(posedge clk);
        sender_hold = 1'b0;
        queue_random_words(PHASE_WORDS / 2);
        wait_idle();

        apply_setting(16'd1, 16'd1, 16'hFFFF, 16'hFFFF);
        queue_random_words(PHASE_WORDS);
        wait_idle();

        apply_setting(16'hFFFF, 16'd0, 16'd3, 16'd0);
        queue_random_words(PHASE_WORDS);
        wait_idle();

        repeat (2)
        begin
            apply_setting(DATA_W'($urandom_range(0, 12)), DATA_W'($urandom_range(0, 12)),
                          DATA_W'($urandom_range(0, 12)), DATA_W'($urandom_range(0, 12)));
            queue_random_words(PHASE_WORDS);
            wait_idle();
        end

        repeat (8) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/kmts_pkg.sv
sv/kmts_item_if.sv
sv/kmts_result_if.sv
sv/kmts_cfg_if.sv
sv/keypad_menu_test_sequencer.sv
verif/tb.sv
